// ----- hdl/aboc_pkg.sv -----
// Package: item types, operation and branch kind codes, prefetch and compact tag constants.
`default_nettype none

package aboc_pkg;

	typedef enum logic {
		OP_COMPRESS   = 1'b0,
		OP_DECOMPRESS = 1'b1
	} aboc_op_t;

	typedef enum logic [2:0] {
		KIND_OFF8  = 3'd0,
		KIND_OFF11 = 3'd1,
		KIND_OFF24 = 3'd2,
		KIND_OFF25 = 3'd3,
		KIND_OFF21 = 3'd4
	} aboc_kind_t;

	// compact opcode tag, bits 15..12
	localparam logic [3:0] TAG_OFF8  = 4'h1;
	localparam logic [3:0] TAG_OFF11 = 4'h2;
	localparam logic [3:0] TAG_OFF24 = 4'h3;
	localparam logic [3:0] TAG_OFF25 = 4'h4;
	localparam logic [3:0] TAG_OFF21 = 4'h5;

	// pipeline lookahead seen by the PC
	localparam logic [3:0] PF_THUMB     = 4'd4;
	localparam logic [3:0] PF_THUMB_MIS = 4'd2;
	localparam logic [3:0] PF_ARM       = 4'd8;

	typedef struct packed {
		logic        operation;
		logic [2:0]  branch_kind;
		logic [31:0] instruction_word;
		logic [31:0] instr_address;
		logic [15:0] compact_op_in;
		logic [31:0] offset_in;
	} aboc_req_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] compact_op_out;
		logic [31:0] offset_out;
		logic [31:0] instruction_out;
	} aboc_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/arm_branch_offset_codec_top.sv -----
// Top level: ARM/Thumb branch offset compress and decompress, two-register pipeline.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) carries one request item: an operation
//   (compress or decompress), a branch kind and the operands for that operation.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result item per
//   request, in order. ok is low for an unknown branch kind, and then every
//   other result field is zero. Fields not produced by the chosen operation
//   are zero.
// Path: a request accepted on cmd is registered in the input stage; its result
//   is registered in the result stage when that stage is free and shows on rsp.
// Throughput: one item per cycle unless rsp stalls. Decode, sign extension
//   and one 32-bit add/subtract sit between the input and result registers.
// Stall: both stages advance together when the result stage is free. While
//   rsp_valid is high and rsp_ready low the result holds and the input stage
//   holds its item; cmd_ready still stays high while the input stage is empty, so
//   up to two items are buffered. cmd_ready follows rsp_ready combinationally.
// Reset: arst_n low empties both stages at once; no result is pending after
//   reset. The block keeps no other state.
`default_nettype none

module arm_branch_offset_codec_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire aboc_pkg::aboc_req_t cmd,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output aboc_pkg::aboc_rsp_t     rsp
);

	aboc_pkg::aboc_req_t req_s1;
	logic                vld_s1;
	aboc_pkg::aboc_rsp_t rsp_s2;
	logic                vld_s2;
	logic                advance;
	aboc_pkg::aboc_rsp_t res;

	// compress intermediates
	logic [31:0] w;
	logic [31:0] off_sext;
	logic [31:0] pf_ext;
	logic        s25;
	logic [24:0] t25;
	logic [20:0] t21;
	logic [3:0]  pf25;

	// decompress intermediates
	logic [31:0] d_sub;
	logic [31:0] d;
	logic        sd;

	// result stage frees up when empty or being taken
	assign advance   = !vld_s2 || rsp_ready;
	assign cmd_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cmd_ready) begin
				vld_s1 <= cmd_valid;
			end
			if (advance) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			req_s1 <= cmd;
		end
		if (advance && vld_s1) begin
			rsp_s2 <= res;
		end
	end

	// Thumb-2 field assembly for the OFF25 and OFF21 compress kinds
	assign w    = req_s1.instruction_word;
	assign s25  = w[26];
	assign t25  = {s25, ~(w[13] ^ s25), ~(w[11] ^ s25), w[25:16], w[10:0], 1'b0};
	assign t21  = {w[26], w[13], w[11], w[21:16], w[10:0], 1'b0};
	// BLX to ARM state from an address that is not word-aligned sees a prefetch of 2
	assign pf25 = (w[14] && !w[12] && (req_s1.instr_address[1:0] != 2'b00))
		? aboc_pkg::PF_THUMB_MIS : aboc_pkg::PF_THUMB;

	// decompress: offset minus prefetch
	always_comb begin
		unique case (req_s1.branch_kind)
			aboc_pkg::KIND_OFF24: d_sub = {28'd0, aboc_pkg::PF_ARM};
			aboc_pkg::KIND_OFF25: d_sub = {28'd0, req_s1.compact_op_in[11:8]};
			default:              d_sub = {28'd0, aboc_pkg::PF_THUMB};
		endcase
	end
	assign d  = req_s1.offset_in - d_sub;
	assign sd = d[24];

	always_comb begin
		res      = '0;
		off_sext = '0;
		pf_ext   = {28'd0, aboc_pkg::PF_THUMB};
		if (req_s1.operation == aboc_pkg::OP_COMPRESS) begin
			res.ok = 1'b1;
			unique case (req_s1.branch_kind)
				aboc_pkg::KIND_OFF8: begin
					off_sext           = {{23{w[7]}}, w[7:0], 1'b0};
					res.compact_op_out = {aboc_pkg::TAG_OFF8, 4'd0, w[15:8]};
				end
				aboc_pkg::KIND_OFF11: begin
					off_sext           = {{20{w[10]}}, w[10:0], 1'b0};
					res.compact_op_out = {aboc_pkg::TAG_OFF11, 7'd0, w[15:11]};
				end
				aboc_pkg::KIND_OFF24: begin
					off_sext           = {{6{w[23]}}, w[23:0], 2'b00};
					pf_ext             = {28'd0, aboc_pkg::PF_ARM};
					res.compact_op_out = {aboc_pkg::TAG_OFF24, 4'd0, w[31:24]};
				end
				aboc_pkg::KIND_OFF25: begin
					off_sext           = {{7{t25[24]}}, t25};
					pf_ext             = {28'd0, pf25};
					res.compact_op_out = {aboc_pkg::TAG_OFF25, pf25, w[31:27], w[15], w[14], w[12]};
				end
				aboc_pkg::KIND_OFF21: begin
					off_sext           = {{11{t21[20]}}, t21};
					res.compact_op_out = {aboc_pkg::TAG_OFF21, 8'd0, w[25:22]};
				end
				default: begin
					res.ok = 1'b0;
				end
			endcase
			if (res.ok) begin
				res.offset_out = off_sext + pf_ext;
			end
		end else begin
			res.ok = 1'b1;
			unique case (req_s1.branch_kind)
				aboc_pkg::KIND_OFF8: begin
					res.instruction_out = {12'd0, req_s1.compact_op_in[11:0], d[8:1]};
				end
				aboc_pkg::KIND_OFF11: begin
					res.instruction_out = {9'd0, req_s1.compact_op_in[11:0], d[11:1]};
				end
				aboc_pkg::KIND_OFF24: begin
					res.instruction_out = {req_s1.compact_op_in[7:0], d[25:2]};
				end
				aboc_pkg::KIND_OFF25: begin
					res.instruction_out = {req_s1.compact_op_in[7:3], sd, d[21:12],
						req_s1.compact_op_in[2], req_s1.compact_op_in[1], ~(d[23] ^ sd),
						req_s1.compact_op_in[0], ~(d[22] ^ sd), d[11:1]};
				end
				aboc_pkg::KIND_OFF21: begin
					res.instruction_out = {4'hF, 1'b0, d[20], req_s1.compact_op_in[3:0],
						d[17:12], 1'b1, 1'b0, d[19], 1'b0, d[18], d[11:1]};
				end
				default: begin
					res.ok = 1'b0;
				end
			endcase
		end
	end

	assign rsp_valid = vld_s2;
	assign rsp       = rsp_s2;

	// input stage holds its item while the result stage is blocked
	ap_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !advance |=> vld_s1 && $stable(req_s1))
		else $error("input stage lost item during stall");

	// rejected kind gives an all-zero result
	ap_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> rsp.compact_op_out == 16'd0 &&
			rsp.offset_out == 32'd0 && rsp.instruction_out == 32'd0)
		else $error("invalid kind produced nonzero fields");

	// compress results carry a known tag and no instruction word
	ap_cmp_tag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.compact_op_out != 16'd0 |-> rsp.instruction_out == 32'd0 &&
			(rsp.compact_op_out[15:12] == aboc_pkg::TAG_OFF8 ||
			 rsp.compact_op_out[15:12] == aboc_pkg::TAG_OFF11 ||
			 rsp.compact_op_out[15:12] == aboc_pkg::TAG_OFF24 ||
			 rsp.compact_op_out[15:12] == aboc_pkg::TAG_OFF25 ||
			 rsp.compact_op_out[15:12] == aboc_pkg::TAG_OFF21))
		else $error("compress result malformed");

	// recorded Thumb-2 BL/BLX prefetch is 2 or 4
	ap_pf25: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.compact_op_out[15:12] == aboc_pkg::TAG_OFF25 |->
			rsp.compact_op_out[11:8] == aboc_pkg::PF_THUMB ||
			rsp.compact_op_out[11:8] == aboc_pkg::PF_THUMB_MIS)
		else $error("bad prefetch in compact opcode");

endmodule

`default_nettype wire
